### src/fcba_pkg.sv
// Shared types and constants for the chained block allocator.
package fcba_pkg;

    localparam int NUM_BLOCKS = 128;
    localparam int BLK_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = BLK_W + 1;
    localparam int LINK_W = 8;

    localparam logic [LINK_W-1:0] LINK_FREE = 8'hFE;
    localparam logic [LINK_W-1:0] LINK_END = 8'hFF;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [7:0] block_number;
        logic       last_block;
    } t_in_word;

    typedef struct packed {
        logic       status;
        logic [6:0] start_block;
        logic [7:0] chain_length;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [BLK_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } t_link_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CRD,
        S_CWR,
        S_CEND,
        S_RES
    } t_state;

endpackage

### src/fcba_link_table.sv
// Link table memory with per-entry written flags; unwritten entries read as free.
module fcba_link_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [fcba_pkg::BLK_W-1:0] i_rd_addr,
    output logic                     o_rd_free,
    input  fcba_pkg::t_link_wr       i_wr
);
    import fcba_pkg::*;

    logic [LINK_W-1:0]     mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_written;
    logic [LINK_W-1:0]     r_rd_data;
    logic                  r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data    <= mem[i_rd_addr];
        r_rd_written <= r_written[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr.we) begin
            r_written[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_free = !r_rd_written || (r_rd_data == LINK_FREE);

endmodule

### src/fat_chain_block_allocator_core.sv
// Top level of the chained block allocator: request checking and chain commit.
//
// Input channel: one word per requested block (block number, last flag), taken
// when i_in_valid is high and o_in_stall is low. Output channel: one word per
// request (status, start block, chain length), taken when o_out_valid is high
// and i_out_stall is low. The user must write the disk size register through
// i_cfg_we / i_cfg_wdata only while the block is idle; the block does not enforce it.
// Each block word goes through a link table read and then a check state.
// The last word of a request that passes every check then walks the pending
// list, reading each block through the pending memory read port (S_CRD) and
// linking it (S_CWR), then writes the end mark (S_CEND) and loads the result
// (S_RES). A failing request goes from its check straight to the result load.
// Reset marks every table entry free at once through per-entry flags, clears
// the pending request and sets the disk size to 128; no clearing pass.
// While the receiver stalls, the result word holds in the output register and
// the next request may be checked; a further result waits until it is taken.
module fat_chain_block_allocator_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fcba_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fcba_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata
);
    import fcba_pkg::*;

    t_state r_state, n_state;
    logic [7:0]            r_blk, n_blk;
    logic                  r_last, n_last;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_ok, n_ok;
    logic [BLK_W-1:0]      r_start, n_start;
    logic [BLK_W-1:0]      r_idx, n_idx;
    logic [BLK_W-1:0]      r_prev, n_prev;
    logic                  r_res_ok, n_res_ok;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;
    logic [7:0]            r_disk;
    logic [NUM_BLOCKS-1:0] r_marks;

    logic [BLK_W-1:0] pend_mem [NUM_BLOCKS];
    logic [BLK_W-1:0] r_pend_q;

    logic             tbl_free;
    t_link_wr         link_wr;
    logic [7:0]       limit;
    logic             hit_ok;
    logic             mark_set;
    logic             mark_clr;
    logic             out_free;

    fcba_link_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (i_in_word.block_number[BLK_W-1:0]),
        .o_rd_free (tbl_free),
        .i_wr      (link_wr)
    );

    assign limit = (r_disk < 8'(NUM_BLOCKS)) ? r_disk : 8'(NUM_BLOCKS);
    assign hit_ok = (r_blk < limit) && tbl_free && !r_marks[r_blk[BLK_W-1:0]]
                    && (r_count < CNT_W'(NUM_BLOCKS));
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_blk       = r_blk;
        n_last      = r_last;
        n_count     = r_count;
        n_ok        = r_ok;
        n_start     = r_start;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_res_ok    = r_res_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mark_set    = 1'b0;
        mark_clr    = 1'b0;
        link_wr     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_blk   = i_in_word.block_number;
                    n_last  = i_in_word.last_block;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (hit_ok) begin
                    mark_set = 1'b1;
                    n_count  = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_start = r_blk[BLK_W-1:0];
                    end
                end
                n_ok = r_ok && hit_ok;
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (n_ok) begin
                    n_idx   = '0;
                    n_state = S_CRD;
                end else begin
                    n_res_ok = 1'b0;
                    n_state  = S_RES;
                end
            end
            S_CRD: begin
                n_state = S_CWR;
            end
            S_CWR: begin
                if (r_idx != '0) begin
                    link_wr.we   = 1'b1;
                    link_wr.addr = r_prev;
                    link_wr.data = LINK_W'(r_pend_q);
                end
                n_prev = r_pend_q;
                if (CNT_W'(r_idx) == r_count - 1'b1) begin
                    n_state = S_CEND;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_CEND: begin
                link_wr.we   = 1'b1;
                link_wr.addr = r_prev;
                link_wr.data = LINK_END;
                n_res_ok     = 1'b1;
                n_state      = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_res_ok) begin
                        n_out.status       = STATUS_OK;
                        n_out.start_block  = r_start;
                        n_out.chain_length = r_count;
                    end else begin
                        n_out.status       = STATUS_FAIL;
                        n_out.start_block  = '0;
                        n_out.chain_length = '0;
                    end
                    mark_clr = 1'b1;
                    n_count  = '0;
                    n_ok     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ok        <= 1'b1;
            r_out_valid <= 1'b0;
            r_disk      <= 8'd128;
            r_marks     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_disk <= i_cfg_wdata;
            end
            if (mark_clr) begin
                r_marks <= '0;
            end else if (mark_set) begin
                r_marks[r_blk[BLK_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk    <= n_blk;
        r_last   <= n_last;
        r_start  <= n_start;
        r_idx    <= n_idx;
        r_prev   <= n_prev;
        r_res_ok <= n_res_ok;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mark_set) begin
            pend_mem[r_count[BLK_W-1:0]] <= r_blk[BLK_W-1:0];
        end
        r_pend_q <= pend_mem[r_idx];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### src/fcba_checker.sv
// Port-level checks for the chained block allocator, bound to the top level.
module fcba_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input fcba_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fcba_pkg::t_out_word o_out_word
);
    import fcba_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == STATUS_FAIL) |->
            (o_out_word.start_block == '0) && (o_out_word.chain_length == '0))
        else $error("failure word carries a chain");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == STATUS_OK) |->
            (o_out_word.chain_length != '0)
            && (o_out_word.chain_length <= 8'(NUM_BLOCKS)))
        else $error("allocated chain length out of range");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block word not given its check cycle");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not cleared by reset");

endmodule

bind fat_chain_block_allocator_core fcba_checker u_fcba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

### tb/sv/fat_chain_block_allocator_core_tb.sv
// Testbench for the chained block allocator: directed table, random requests, scoreboard.
`timescale 1ns / 100ps

module fat_chain_block_allocator_core_tb;
    import fcba_pkg::*;

    localparam int DIR_N = 21;
    localparam int RAND_ITEMS = 2000;
    localparam int PHASES = 6;
    localparam int IDLE_PCT = 21;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 2 * NUM_BLOCKS + 16;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word r;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;

    logic [LINK_W-1:0] fat_links [NUM_BLOCKS];
    logic              req_mark [NUM_BLOCKS];
    logic [BLK_W-1:0]  req_chain [$];
    logic              req_ok;
    logic [7:0]        disk_size;
    t_out_word         alloc_results_q [$];
    t_out_word         want;

    t_dir_row   dir_rows [DIR_N];
    logic [7:0] phase_disk [PHASES];
    bit         quiet = 1'b0;
    int         items = 0;
    int         errors = 0;
    int         cycles = 0;

    fat_chain_block_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("fat_chain_block_allocator_core_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (alloc_results_q.size() == 0) begin
                $display("%0t: unexpected result word expected none got %p", $time, o_out_word);
                errors++;
            end else begin
                want = alloc_results_q.pop_front();
                if (o_out_word.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_out_word.status);
                    errors++;
                end
                if (o_out_word.start_block !== want.start_block) begin
                    $display("%0t: start_block expected %0d got %0d",
                             $time, want.start_block, o_out_word.start_block);
                    errors++;
                end
                if (o_out_word.chain_length !== want.chain_length) begin
                    $display("%0t: chain_length expected %0d got %0d",
                             $time, want.chain_length, o_out_word.chain_length);
                    errors++;
                end
            end
        end
    end

    function automatic void clear_table();
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            fat_links[b] = LINK_FREE;
            req_mark[b] = 1'b0;
        end
        req_chain.delete();
        req_ok = 1'b1;
        disk_size = 8'd128;
    endfunction

    function automatic int disk_limit();
        return (disk_size < NUM_BLOCKS) ? int'(disk_size) : NUM_BLOCKS;
    endfunction

    function automatic void allocate_block(input t_in_word w, output bit has_res,
                                           output t_out_word res);
        logic [7:0] blk;
        int         n;
        blk = w.block_number;
        has_res = 1'b0;
        res = '0;
        if (blk >= disk_limit()) begin
            req_ok = 1'b0;
        end else if (fat_links[blk] != LINK_FREE || req_mark[blk]) begin
            req_ok = 1'b0;
        end else if (req_chain.size() >= NUM_BLOCKS) begin
            req_ok = 1'b0;
        end else begin
            req_mark[blk] = 1'b1;
            req_chain.push_back(blk[BLK_W-1:0]);
        end
        if (w.last_block) begin
            has_res = 1'b1;
            n = req_chain.size();
            if (req_ok && n > 0) begin
                for (int i = 0; i + 1 < n; i++)
                    fat_links[req_chain[i]] = LINK_W'(req_chain[i + 1]);
                fat_links[req_chain[n - 1]] = LINK_END;
                res.status = STATUS_OK;
                res.start_block = req_chain[0];
                res.chain_length = n[7:0];
            end else begin
                res.status = STATUS_FAIL;
            end
            for (int b = 0; b < NUM_BLOCKS; b++)
                req_mark[b] = 1'b0;
            req_chain.delete();
            req_ok = 1'b1;
        end
    endfunction

    task automatic send_word(input t_in_word w, input logic typed, input t_out_word typed_res);
        bit        fire;
        bit        has_res;
        t_out_word res;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do begin
            @(negedge i_clk);
            fire = i_in_valid && !o_in_stall;
            @(posedge i_clk);
        end while (!fire);
        allocate_block(w, has_res, res);
        if (has_res)
            alloc_results_q.push_back(typed ? typed_res : res);
        items++;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic set_disk(input logic [7:0] value);
        i_in_valid <= 1'b0;
        while (alloc_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        disk_size = value;
    endtask

    task automatic run_request(input bit longest);
        logic [7:0] blks [$];
        int         cand [$];
        int         kind;
        int         len;
        int         idx;
        int         b;
        int         k;
        logic [7:0] bad;
        t_in_word   w;
        for (b = 0; b < NUM_BLOCKS; b++)
            if (b < disk_limit() && fat_links[b] == LINK_FREE)
                cand.push_back(b);
        kind = $urandom_range(99);
        if (longest)
            len = cand.size() + 1;
        else if (kind < 85)
            len = ($urandom_range(9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        else
            len = $urandom_range(1, 6);
        if (longest || kind < 85) begin
            repeat (len) begin
                if (cand.size() > 0) begin
                    idx = $urandom_range(cand.size() - 1);
                    blks.push_back(8'(cand[idx]));
                    cand.delete(idx);
                end else begin
                    blks.push_back(8'($urandom_range(255)));
                end
            end
        end else begin
            repeat (len) blks.push_back(8'($urandom_range(255)));
        end
        if (longest) begin
            while (blks.size() < NUM_BLOCKS + 2)
                blks.push_back($urandom_range(1) ? blks[0] : 8'($urandom_range(255)));
        end else if (kind >= 70 && kind < 85) begin
            case ($urandom_range(2))
                0: begin
                    bad = blks[0];
                end
                1: begin
                    bad = 8'($urandom_range(128, 255));
                end
                default: begin
                    bad = 8'($urandom_range(255));
                end
            endcase
            blks.insert($urandom_range(blks.size()), bad);
        end
        for (k = 0; k < blks.size(); k++) begin
            w.block_number = blks[k];
            w.last_block = (k == blks.size() - 1) ||
                           (!longest && kind >= 85 && $urandom_range(3) == 0);
            send_word(w, 1'b0, '0);
        end
    endtask

    initial begin
        int start;
        dir_rows = '{
            '{'{8'd5,   1'b1}, 1'b1, '{STATUS_OK,   7'd5,  8'd1}},
            '{'{8'd128, 1'b1}, 1'b1, '{STATUS_FAIL, 7'd0,  8'd0}},
            '{'{8'd255, 1'b1}, 1'b1, '{STATUS_FAIL, 7'd0,  8'd0}},
            '{'{8'd5,   1'b1}, 1'b1, '{STATUS_FAIL, 7'd0,  8'd0}},
            '{'{8'd0,   1'b0}, 1'b0, '0},
            '{'{8'd127, 1'b1}, 1'b1, '{STATUS_OK,   7'd0,  8'd2}},
            '{'{8'd10,  1'b0}, 1'b0, '0},
            '{'{8'd10,  1'b1}, 1'b1, '{STATUS_FAIL, 7'd0,  8'd0}},
            '{'{8'd11,  1'b0}, 1'b0, '0},
            '{'{8'd12,  1'b0}, 1'b0, '0},
            '{'{8'd13,  1'b1}, 1'b1, '{STATUS_OK,   7'd11, 8'd3}},
            '{'{8'd20,  1'b0}, 1'b0, '0},
            '{'{8'd255, 1'b0}, 1'b0, '0},
            '{'{8'd21,  1'b1}, 1'b1, '{STATUS_FAIL, 7'd0,  8'd0}},
            '{'{8'd12,  1'b0}, 1'b0, '0},
            '{'{8'd30,  1'b1}, 1'b1, '{STATUS_FAIL, 7'd0,  8'd0}},
            '{'{8'd30,  1'b1}, 1'b1, '{STATUS_OK,   7'd30, 8'd1}},
            '{'{8'd20,  1'b0}, 1'b0, '0},
            '{'{8'd21,  1'b0}, 1'b0, '0},
            '{'{8'd22,  1'b0}, 1'b0, '0},
            '{'{8'd23,  1'b1}, 1'b0, '0}
        };
        phase_disk = '{8'd255, 8'd64, 8'd0, 8'd1, 8'd128, 8'd0};
        clear_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++)
            send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].r);

        for (int p = 0; p < PHASES; p++) begin
            set_disk((p == PHASES - 1) ? 8'($urandom_range(1, 255)) : phase_disk[p]);
            quiet = (p == 1);
            start = items;
            if (p == 0)
                run_request(1'b1);
            while (items - start < RAND_ITEMS / PHASES)
                run_request(1'b0);
        end
        quiet = 1'b0;

        i_in_valid <= 1'b0;
        while (alloc_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("fat_chain_block_allocator_core_tb passed");
        end else begin
            $display("fat_chain_block_allocator_core_tb failed");
        end
        $finish;
    end

endmodule
